### hw/rtl/dependent_approval_table_macros.svh
// assertion macros used by the rtl sequencer dat_ctrl
`ifndef DEPENDENT_APPROVAL_TABLE_MACROS_SVH
`define DEPENDENT_APPROVAL_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// types, codes and defaults shared by the approval table files
// ----------------------------------------------------------------------------
package dat_pkg;

   localparam int ENTRIES_DEF = 256;

   localparam logic [31:0] TTL_RESET       = 32'd6000;
   localparam logic        SOVEREIGN_RESET = 1'b1;

   // entry status codes
   localparam logic [2:0] ST_FREE     = 3'd0;
   localparam logic [2:0] ST_PENDING  = 3'd1;
   localparam logic [2:0] ST_APPROVED = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_EXPIRED  = 3'd4;

   // error codes
   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_NO_ENTRY    = 3'd1;
   localparam logic [2:0] ERR_FULL        = 3'd2;
   localparam logic [2:0] ERR_NOT_PENDING = 3'd3;
   localparam logic [2:0] ERR_PARENT      = 3'd4;

   // actions
   localparam logic [1:0] ACT_SUBMIT = 2'd0;
   localparam logic [1:0] ACT_POLL   = 2'd1;
   localparam logic [1:0] ACT_DECIDE = 2'd2;
   localparam logic [1:0] ACT_DROP   = 2'd3;

   // configuration register indexes
   localparam logic CSR_SOVEREIGN = 1'b0;
   localparam logic CSR_TTL       = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] owner_pid;
      logic [31:0] request_type;
      logic        forces_pending;
      logic [63:0] entry_id;
      logic [63:0] parent_id;
      logic        approve;
      logic [63:0] now_tick;
   } item_type;

   typedef struct packed {
      logic [2:0]  error;
      logic [63:0] new_id;
      logic [2:0]  entry_status;
   } result_type;

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] parent;
      logic [31:0] owner;
      logic [31:0] rtype;
      logic [63:0] tick;
   } entry_type;

   // write strobes from the sequencer to the table memories
   typedef struct packed {
      logic       st_we;
      logic       dt_we;
      logic [2:0] st_val;
   } mem_wr_type;

endpackage

### hw/rtl/dat_mem.sv
// ----------------------------------------------------------------------------
// dat_mem
// status memory and entry data memory, one write and one registered read each
// ----------------------------------------------------------------------------
module dat_mem #(
   parameter int ENTRIES = dat_pkg::ENTRIES_DEF,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic [IW-1:0]       rd_addr,
   input  logic [IW-1:0]       wr_addr,
   input  dat_pkg::mem_wr_type wr,
   input  dat_pkg::entry_type  wr_data,
   output logic [2:0]          rd_st,
   output dat_pkg::entry_type  rd_dat
);

   logic [2:0]         st_mem [ENTRIES];
   dat_pkg::entry_type dt_mem [ENTRIES];
   logic [2:0]         rd_st_ff;
   dat_pkg::entry_type rd_dat_ff;

   always_ff @(posedge clock) begin
      if (wr.st_we) begin
         st_mem[wr_addr] <= wr.st_val;
      end
      if (wr.dt_we) begin
         dt_mem[wr_addr] <= wr_data;
      end
      rd_st_ff  <= st_mem[rd_addr];
      rd_dat_ff <= dt_mem[rd_addr];
   end

   assign rd_st  = rd_st_ff;
   assign rd_dat = rd_dat_ff;

endmodule

### hw/rtl/dat_ctrl.sv
// ----------------------------------------------------------------------------
// dat_ctrl
// sequencer that sweeps the table memories read-modify-write, reading each
// entry and then evaluating and writing it back
// ----------------------------------------------------------------------------
`include "dependent_approval_table_macros.svh"

module dat_ctrl #(
   parameter int ENTRIES = dat_pkg::ENTRIES_DEF,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dat_pkg::item_type    req_item,
   input  logic                 sovereign,
   input  logic [31:0]          ttl,
   input  logic                 out_free,
   output logic                 res_valid,
   output dat_pkg::result_type  res,
   output logic [IW-1:0]        mem_addr,
   output logic [IW-1:0]        wr_addr,
   output dat_pkg::mem_wr_type  wr,
   output dat_pkg::entry_type   wr_data,
   input  logic [2:0]           rd_st,
   input  dat_pkg::entry_type   rd_dat
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EVAL, S_ALLOC, S_DEC, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_PAR, PH_SWEEP, PH_FIND, PH_DPAR, PH_DROP
   } phase_type;

   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   state_type           state_ff,  state_in;
   phase_type           phase_ff,  phase_in;
   logic [IW-1:0]       idx_ff,    idx_in;
   dat_pkg::item_type   item_ff,   item_in;
   logic [IW-1:0]       par_idx_ff, par_idx_in;
   logic [2:0]          par_st_ff, par_st_in;
   logic                free_ok_ff, free_ok_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [IW-1:0]       slot_ff,   slot_in;
   logic [63:0]         par_id_ff, par_id_in;
   logic                dec_ok_ff, dec_ok_in;
   dat_pkg::result_type res_ff,    res_in;
   logic [63:0]         next_id_ff, next_id_in;

   logic                live;
   logic                overdue;
   logic [2:0]          st_now;
   logic [63:0]         age;

   assign age     = item_ff.now_tick - rd_dat.tick;
   assign live    = (rd_st != dat_pkg::ST_FREE);
   assign overdue = (rd_st == dat_pkg::ST_PENDING) && (age > {32'd0, ttl});
   assign st_now  = overdue ? dat_pkg::ST_EXPIRED : rd_st;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      item_in     = item_ff;
      par_idx_in  = par_idx_ff;
      par_st_in   = par_st_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      slot_in     = slot_ff;
      par_id_in   = par_id_ff;
      dec_ok_in   = dec_ok_ff;
      res_in      = res_ff;
      next_id_in  = next_id_ff;
      wr          = '0;
      wr_addr     = idx_ff;
      wr_data     = '{id: next_id_ff, parent: item_ff.parent_id, owner: item_ff.owner_pid,
                      rtype: item_ff.request_type, tick: item_ff.now_tick};

      unique case (state_ff)
         S_CLEAR: begin
            wr.st_we  = 1'b1;
            wr.st_val = dat_pkg::ST_FREE;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST) begin
               state_in = S_IDLE;
               idx_in   = '0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in    = req_item;
               idx_in     = '0;
               free_ok_in = 1'b0;
               par_st_in  = dat_pkg::ST_FREE;
               res_in     = '{error: dat_pkg::ERR_OK, new_id: 64'd0,
                              entry_status: dat_pkg::ST_FREE};
               state_in   = S_READ;
               unique case (req_item.action) inside
                  dat_pkg::ACT_SUBMIT:
                     phase_in = (req_item.parent_id != 64'd0) ? PH_PAR : PH_SWEEP;
                  dat_pkg::ACT_POLL, dat_pkg::ACT_DECIDE: phase_in = PH_FIND;
                  default: phase_in = PH_DROP;
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_READ;
            idx_in   = idx_ff + 1'b1;
            unique case (phase_ff)
               PH_PAR: begin
                  if (live && rd_dat.id == item_ff.parent_id) begin
                     par_idx_in = idx_ff;
                     phase_in   = PH_SWEEP;
                     idx_in     = '0;
                  end else if (idx_ff == LAST) begin
                     res_in.error = dat_pkg::ERR_NO_ENTRY;
                     state_in     = S_DONE;
                  end
               end
               PH_SWEEP: begin
                  if (overdue) begin
                     wr.st_we  = 1'b1;
                     wr.st_val = dat_pkg::ST_EXPIRED;
                  end
                  if (!free_ok_ff && st_now == dat_pkg::ST_FREE) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (item_ff.parent_id != 64'd0 && idx_ff == par_idx_ff) begin
                     par_st_in = st_now;
                  end
                  if (idx_ff == LAST) begin
                     state_in = S_ALLOC;
                  end
               end
               PH_FIND: begin
                  if (live && rd_dat.id == item_ff.entry_id) begin
                     state_in = S_DONE;
                     if (item_ff.action == dat_pkg::ACT_POLL) begin
                        if (rd_dat.owner == item_ff.owner_pid) begin
                           res_in.entry_status = st_now;
                           if (st_now != dat_pkg::ST_PENDING) begin
                              wr.st_we  = 1'b1;
                              wr.st_val = dat_pkg::ST_FREE;
                           end
                        end else begin
                           res_in.error = dat_pkg::ERR_NO_ENTRY;
                        end
                     end else if (rd_st != dat_pkg::ST_PENDING) begin
                        res_in.error = dat_pkg::ERR_NOT_PENDING;
                     end else if (!item_ff.approve) begin
                        wr.st_we  = 1'b1;
                        wr.st_val = dat_pkg::ST_REJECTED;
                     end else if (rd_dat.parent == 64'd0) begin
                        wr.st_we  = 1'b1;
                        wr.st_val = dat_pkg::ST_APPROVED;
                     end else begin
                        // approval needs the parent's status: second sweep
                        slot_in   = idx_ff;
                        par_id_in = rd_dat.parent;
                        phase_in  = PH_DPAR;
                        idx_in    = '0;
                        state_in  = S_READ;
                     end
                  end else if (idx_ff == LAST) begin
                     res_in.error = dat_pkg::ERR_NO_ENTRY;
                     state_in     = S_DONE;
                  end
               end
               PH_DPAR: begin
                  if (live && rd_dat.id == par_id_ff) begin
                     dec_ok_in = (rd_st == dat_pkg::ST_APPROVED);
                     state_in  = S_DEC;
                  end else if (idx_ff == LAST) begin
                     dec_ok_in = 1'b0;
                     state_in  = S_DEC;
                  end
               end
               default: begin
                  if (live && rd_dat.owner == item_ff.owner_pid) begin
                     wr.st_we  = 1'b1;
                     wr.st_val = dat_pkg::ST_FREE;
                  end
                  if (idx_ff == LAST) begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_ALLOC: begin
            state_in = S_DONE;
            wr_addr  = free_idx_ff;
            if (!free_ok_ff) begin
               res_in.error = dat_pkg::ERR_FULL;
            end else begin
               wr.st_we  = 1'b1;
               wr.dt_we  = 1'b1;
               wr.st_val = (!item_ff.forces_pending && sovereign &&
                            (item_ff.parent_id == 64'd0 ||
                             par_st_ff == dat_pkg::ST_APPROVED))
                           ? dat_pkg::ST_APPROVED : dat_pkg::ST_PENDING;
               res_in.new_id = next_id_ff;
               next_id_in    = next_id_ff + 64'd1;
            end
         end
         S_DEC: begin
            state_in = S_DONE;
            wr_addr  = slot_ff;
            if (dec_ok_ff) begin
               wr.st_we  = 1'b1;
               wr.st_val = dat_pkg::ST_APPROVED;
            end else begin
               res_in.error = dat_pkg::ERR_PARENT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         phase_ff   <= PH_PAR;
         idx_ff     <= '0;
         free_ok_ff <= 1'b0;
         dec_ok_ff  <= 1'b0;
         next_id_ff <= 64'd1;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         free_ok_ff <= free_ok_in;
         dec_ok_ff  <= dec_ok_in;
         next_id_ff <= next_id_in;
      end
      item_ff     <= item_in;
      par_idx_ff  <= par_idx_in;
      par_st_ff   <= par_st_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      par_id_ff   <= par_id_in;
      res_ff      <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE) && out_free;
   assign res       = res_ff;
   assign mem_addr  = idx_ff;

   `DAT_ASSERT_NOW(a_no_write_idle, clock, reset, state_ff == S_IDLE, !wr.st_we && !wr.dt_we, "table written while idle")
   `DAT_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && req_ready, state_ff == S_READ, "accepted item did not start a read")
   `DAT_ASSERT_NEXT(a_result_idle, clock, reset, res_valid, state_ff == S_IDLE, "sequencer not idle after result")
   `DAT_ASSERT_NOW(a_data_only_alloc, clock, reset, wr.dt_we, state_ff == S_ALLOC && free_ok_ff, "entry data written outside allocation")

endmodule

### hw/rtl/dependent_approval_table.sv
// ----------------------------------------------------------------------------
// dependent_approval_table
// table of dependent approval requests with submit, poll, decide and drop
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the status memory and takes no
// request during that time; configuration writes are taken at once.
// Every request is served by sweeping the table memories entry by entry (read,
// then evaluate and write back). A submit without a parent makes one sweep, a
// submit with a parent first searches for the parent and then sweeps; a poll or
// decide stops at the first matching entry, and an approving decide with a
// parent adds a second sweep that searches for the parent; a drop always sweeps
// the whole table. The result is held in an output register,
// so the next request may be accepted while the last result waits.
module dependent_approval_table #(
   parameter int ENTRIES = dat_pkg::ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: owner_pid[31:0], request_type[63:32], forces_pending[64],
   // entry_id[128:65], parent_id[192:129], approve[193], now_tick[257:194]
   input  logic [263:0] req_tdata,
   // req_tuser: action[1:0]
   input  logic [1:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata: error[2:0], new_id[66:3], entry_status[69:67]
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int IW = $clog2(ENTRIES);

   logic                sov_ff;
   logic [31:0]         ttl_ff;
   logic                rsp_valid_ff;
   dat_pkg::result_type rsp_ff;

   dat_pkg::item_type   item;
   dat_pkg::result_type res;
   logic                res_valid;
   logic                out_free;
   logic [IW-1:0]       mem_addr;
   logic [IW-1:0]       wr_addr;
   dat_pkg::mem_wr_type wr;
   dat_pkg::entry_type  wr_data;
   logic [2:0]          rd_st;
   dat_pkg::entry_type  rd_dat;

   assign item = '{action: req_tuser,
                   owner_pid: req_tdata[31:0],
                   request_type: req_tdata[63:32],
                   forces_pending: req_tdata[64],
                   entry_id: req_tdata[128:65],
                   parent_id: req_tdata[192:129],
                   approve: req_tdata[193],
                   now_tick: req_tdata[257:194]};

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sov_ff       <= dat_pkg::SOVEREIGN_RESET;
         ttl_ff       <= dat_pkg::TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               dat_pkg::CSR_SOVEREIGN: sov_ff <= csr_wdata[0];
               default:                ttl_ff <= csr_wdata;
            endcase
         end
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.entry_status, rsp_ff.new_id, rsp_ff.error};

   dat_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (item),
      .sovereign (sov_ff),
      .ttl       (ttl_ff),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .mem_addr  (mem_addr),
      .wr_addr   (wr_addr),
      .wr        (wr),
      .wr_data   (wr_data),
      .rd_st     (rd_st),
      .rd_dat    (rd_dat)
   );

   dat_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .rd_addr (mem_addr),
      .wr_addr (wr_addr),
      .wr      (wr),
      .wr_data (wr_data),
      .rd_st   (rd_st),
      .rd_dat  (rd_dat)
   );

endmodule

### tb/dependent_approval_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dependent_approval_table_test
// checks the approval table against a behavioral model of its entries
// ----------------------------------------------------------------------------
// A directed sequence covers auto approval, forced pending, parent ordering,
// foreign polls, expiry across tick wrap and the error codes. Random phases
// under several mode and ttl settings then mix submits, polls, decides and
// drops, with one submit-heavy phase that fills the table. Every response is
// compared field by field with the model's prediction, in order.
module dependent_approval_table_test;

   localparam int  SLOTS      = 256;
   localparam int  CYCLE_STOP = 10000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [263:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = dat_pkg::CSR_SOVEREIGN;
   logic [31:0]  csr_wdata = '0;

   dependent_approval_table uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // model of the table
   logic [2:0]  tbl_status [SLOTS];
   logic [63:0] tbl_id     [SLOTS];
   logic [63:0] tbl_parent [SLOTS];
   logic [31:0] tbl_owner  [SLOTS];
   logic [63:0] tbl_tick   [SLOTS];
   logic [63:0] id_counter = 64'd1;
   logic        mdl_sovereign = dat_pkg::SOVEREIGN_RESET;
   logic [31:0] mdl_ttl = dat_pkg::TTL_RESET;

   dat_pkg::item_type   request_backlog [$];
   dat_pkg::result_type awaited_results [$];
   int         queued_count = 0;
   int         accepted_count = 0;
   int         csr_writes = 0;
   int         fail_count = 0;
   int         cycle_count = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_status[i] = dat_pkg::ST_FREE;
      end
   end

   function automatic bit overdue(int i, logic [63:0] now);
      return tbl_status[i] == dat_pkg::ST_PENDING &&
             (now - tbl_tick[i]) > {32'd0, mdl_ttl};
   endfunction

   function automatic int find_live(logic [63:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_status[i] != dat_pkg::ST_FREE && tbl_id[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic bit parent_ok(logic [63:0] pid);
      int p;
      p = find_live(pid);
      return p >= 0 && tbl_status[p] == dat_pkg::ST_APPROVED;
   endfunction

   function automatic dat_pkg::result_type apply_request(dat_pkg::item_type r);
      dat_pkg::result_type res;
      int slot;
      bit ready;
      logic [2:0] s;
      res = '0;
      case (r.action)
         dat_pkg::ACT_SUBMIT: begin
            if (r.parent_id != 0 && find_live(r.parent_id) < 0) begin
               res.error = dat_pkg::ERR_NO_ENTRY;
            end else begin
               slot = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (overdue(i, r.now_tick)) tbl_status[i] = dat_pkg::ST_EXPIRED;
                  if (slot < 0 && tbl_status[i] == dat_pkg::ST_FREE) slot = i;
               end
               if (slot < 0) begin
                  res.error = dat_pkg::ERR_FULL;
               end else begin
                  tbl_id[slot] = id_counter;
                  id_counter = id_counter + 1;
                  tbl_parent[slot] = r.parent_id;
                  tbl_owner[slot] = r.owner_pid;
                  tbl_tick[slot] = r.now_tick;
                  tbl_status[slot] = dat_pkg::ST_PENDING;
                  ready = (r.parent_id == 0) || parent_ok(r.parent_id);
                  if (!r.forces_pending && mdl_sovereign && ready)
                     tbl_status[slot] = dat_pkg::ST_APPROVED;
                  res.new_id = tbl_id[slot];
               end
            end
         end
         dat_pkg::ACT_POLL: begin
            res.error = dat_pkg::ERR_NO_ENTRY;
            slot = find_live(r.entry_id);
            if (r.entry_id == 0) begin
               // find_live already rejects id 0, and no live slot ever holds id 0
               slot = -1;
            end
            if (slot >= 0 && tbl_owner[slot] == r.owner_pid) begin
               if (overdue(slot, r.now_tick)) tbl_status[slot] = dat_pkg::ST_EXPIRED;
               s = tbl_status[slot];
               if (s != dat_pkg::ST_PENDING) tbl_status[slot] = dat_pkg::ST_FREE;
               res.error = dat_pkg::ERR_OK;
               res.entry_status = s;
            end
         end
         dat_pkg::ACT_DECIDE: begin
            res.error = dat_pkg::ERR_NO_ENTRY;
            slot = (r.entry_id == 0) ? -1 : find_live(r.entry_id);
            if (slot >= 0) begin
               if (tbl_status[slot] != dat_pkg::ST_PENDING) begin
                  res.error = dat_pkg::ERR_NOT_PENDING;
               end else if (r.approve && tbl_parent[slot] != 0
                            && !parent_ok(tbl_parent[slot])) begin
                  res.error = dat_pkg::ERR_PARENT;
               end else begin
                  tbl_status[slot] = r.approve ? dat_pkg::ST_APPROVED
                                               : dat_pkg::ST_REJECTED;
                  res.error = dat_pkg::ERR_OK;
               end
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_status[i] != dat_pkg::ST_FREE && tbl_owner[i] == r.owner_pid)
                  tbl_status[i] = dat_pkg::ST_FREE;
            end
         end
      endcase
      return res;
   endfunction

   // ---------------- request driver ----------------
   int  req_gap = 0;
   int  req_calm = 0;

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) calm = 30;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   always @(posedge clock) begin
      dat_pkg::item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            nxt.action = req_tuser;
            {nxt.now_tick, nxt.approve, nxt.parent_id, nxt.entry_id,
             nxt.forces_pending, nxt.request_type, nxt.owner_pid} = req_tdata[257:0];
            awaited_results.push_back(apply_request(nxt));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               nxt = request_backlog.pop_front();
               req_tuser <= nxt.action;
               req_tdata <= {6'd0, nxt.now_tick, nxt.approve, nxt.parent_id,
                             nxt.entry_id, nxt.forces_pending, nxt.request_type,
                             nxt.owner_pid};
               req_tvalid <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response monitor ----------------
   int rsp_stall = 0;
   int rsp_calm = 0;

   always @(posedge clock) begin
      dat_pkg::result_type got, want;
      cycle_count++;
      if (cycle_count > CYCLE_STOP) begin
         $display("tb: failure");
         $finish;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == dat_pkg::CSR_SOVEREIGN) mdl_sovereign = csr_wdata[0];
            else mdl_ttl = csr_wdata;
            csr_writes++;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.error = rsp_tdata[2:0];
            got.new_id = rsp_tdata[66:3];
            got.entry_status = rsp_tdata[69:67];
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected transfer %h", $time, got);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (got.error !== want.error) begin
                  $display("%0t: error exp %0d got %0d", $time, want.error, got.error);
                  fail_count++;
               end
               if (got.new_id !== want.new_id) begin
                  $display("%0t: new_id exp %h got %h", $time, want.new_id, got.new_id);
                  fail_count++;
               end
               if (got.entry_status !== want.entry_status) begin
                  $display("%0t: entry_status exp %0d got %0d", $time,
                           want.entry_status, got.entry_status);
                  fail_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = pick_gap(rsp_calm);
         end
      end
   end

   // ---------------- stimulus ----------------
   logic [63:0] tick_now = 64'd100;
   logic [63:0] submits_made = 64'd0;

   task automatic add_item(logic [1:0] act, logic [31:0] owner, logic [31:0] rtype,
                           logic forced, logic [63:0] eid, logic [63:0] pid,
                           logic appr, logic [63:0] now);
      dat_pkg::item_type it;
      it.action = act;
      it.owner_pid = owner;
      it.request_type = rtype;
      it.forces_pending = forced;
      it.entry_id = eid;
      it.parent_id = pid;
      it.approve = appr;
      it.now_tick = now;
      if (act == dat_pkg::ACT_SUBMIT) submits_made++;
      request_backlog.push_back(it);
      queued_count++;
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      int seen;
      seen = csr_writes;
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      wait (csr_writes != seen);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (accepted_count == queued_count && awaited_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] near_id();
      logic [63:0] back;
      back = $urandom_range(0, 60);
      return (submits_made > back) ? submits_made - back + 1 : 64'd1;
   endfunction

   task automatic random_phase(int count, int submit_pct, int drop_pct, int step);
      int r;
      logic [1:0] act;
      logic [31:0] owner;
      logic [63:0] pid, eid;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < submit_pct) act = dat_pkg::ACT_SUBMIT;
         else if (r < submit_pct + drop_pct) act = dat_pkg::ACT_DROP;
         else if (r % 2) act = dat_pkg::ACT_POLL;
         else act = dat_pkg::ACT_DECIDE;
         owner = ($urandom_range(0, 99) < 4) ? $urandom : $urandom_range(1, 6);
         r = $urandom_range(0, 99);
         pid = (r < 50) ? 64'd0 : (r < 95) ? near_id() : {$urandom, $urandom};
         eid = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : near_id();
         if ($urandom_range(0, 99) < 2) tick_now = {$urandom, $urandom};
         else tick_now = tick_now + $urandom_range(0, step);
         add_item(act, owner, $urandom, $urandom_range(0, 99) < 30, eid, pid,
                  $urandom_range(0, 1), tick_now);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: auto approval, parent chains, errors, wrap expiry
      add_item(dat_pkg::ACT_SUBMIT, 5, 7, 0, 0, 0, 0, 100);
      add_item(dat_pkg::ACT_SUBMIT, 5, 7, 1, 0, 0, 0, 101);
      add_item(dat_pkg::ACT_SUBMIT, 6, 8, 0, 0, 1, 0, 102);
      add_item(dat_pkg::ACT_SUBMIT, 6, 8, 0, 0, 2, 0, 103);
      add_item(dat_pkg::ACT_SUBMIT, 6, 8, 0, 0, 999, 0, 104);
      add_item(dat_pkg::ACT_DECIDE, 0, 0, 0, 4, 0, 1, 105);
      add_item(dat_pkg::ACT_DECIDE, 0, 0, 0, 2, 0, 1, 106);
      add_item(dat_pkg::ACT_DECIDE, 0, 0, 0, 4, 0, 1, 107);
      add_item(dat_pkg::ACT_DECIDE, 0, 0, 0, 3, 0, 0, 108);
      add_item(dat_pkg::ACT_POLL, 6, 0, 0, 1, 0, 0, 109);
      add_item(dat_pkg::ACT_POLL, 5, 0, 0, 1, 0, 0, 110);
      add_item(dat_pkg::ACT_POLL, 5, 0, 0, 1, 0, 0, 111);
      add_item(dat_pkg::ACT_SUBMIT, '1, '1, 1, 0, 0, 1, '1);
      add_item(dat_pkg::ACT_POLL, '1, 0, 0, 5, 0, 0, 64'd7000);
      add_item(dat_pkg::ACT_SUBMIT, 7, 0, 1, '1, 0, 0, 200);
      add_item(dat_pkg::ACT_DECIDE, 7, 0, 0, 6, 0, 0, 201);
      add_item(dat_pkg::ACT_POLL, 7, 0, 0, 6, 0, 0, 202);
      add_item(dat_pkg::ACT_DROP, 6, 0, 0, 0, 0, 0, 203);
      add_item(dat_pkg::ACT_DECIDE, 0, 0, 0, '1, 0, 1, 204);
      add_item(dat_pkg::ACT_POLL, 5, 0, 0, 0, 0, 0, 205);
      add_item(dat_pkg::ACT_SUBMIT, 5, 0, 0, 0, '1, 0, 206);
      add_item(dat_pkg::ACT_POLL, 5, 0, 0, 2, 0, 0, 207);
      tick_now = 300;
      random_phase(170, 45, 5, 60);
      wait_idle();

      write_csr(dat_pkg::CSR_SOVEREIGN, 32'd0);
      write_csr(dat_pkg::CSR_TTL, 32'd0);
      random_phase(160, 45, 5, 3);
      wait_idle();

      // maximum ttl, heavy submits to fill the table
      write_csr(dat_pkg::CSR_SOVEREIGN, 32'd1);
      write_csr(dat_pkg::CSR_TTL, 32'hFFFF_FFFF);
      random_phase(340, 88, 1, 50);
      wait_idle();

      write_csr(dat_pkg::CSR_TTL, 32'd300);
      random_phase(160, 40, 8, 40);
      wait_idle();

      write_csr(dat_pkg::CSR_SOVEREIGN, 32'd0);
      write_csr(dat_pkg::CSR_TTL, 32'd5000);
      random_phase(150, 45, 5, 100);
      wait_idle();

      write_csr(dat_pkg::CSR_SOVEREIGN, 32'd1);
      write_csr(dat_pkg::CSR_TTL, 32'd6000);
      random_phase(150, 50, 5, 80);
      wait_idle();

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
